FILE: rtl/xrg_pkg.sv
// Shared types and constants for the xoshiro256++ range generator.
`timescale 1ns / 1ps
`default_nettype none

package xrg_pkg;

   localparam int WordWidth     = 64;
   localparam int BoundWidth    = 32;
   localparam int SpanWidth     = BoundWidth + 1;
   localparam int SeedCount     = 4;
   localparam int SeedIdxWidth  = 2;
   localparam int CsrAddrWidth  = 5;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = 2;
   localparam int QueueCntWidth = QueuePtrWidth + 1;

   localparam logic [WordWidth-1:0] Seed0Reset = 64'hDEADBEAFDEADBEAF;
   localparam logic [WordWidth-1:0] Seed1Reset = 64'hABADCAFEABADCAFE;
   localparam logic [WordWidth-1:0] Seed2Reset = 64'hCDCDCDCDCDCDCDCD;
   localparam logic [WordWidth-1:0] Seed3Reset = 64'hA5A5A5A5A5A5A5A5;

   // register indexes
   localparam logic [SeedIdxWidth-1:0] RegSeed0 = 2'd0;
   localparam logic [SeedIdxWidth-1:0] RegSeed1 = 2'd1;
   localparam logic [SeedIdxWidth-1:0] RegSeed2 = 2'd2;
   localparam logic [SeedIdxWidth-1:0] RegSeed3 = 2'd3;

   // one classified request, handed from front to back
   typedef struct packed {
      logic                  bad;
      logic [BoundWidth-1:0] lower;
      logic [SpanWidth-1:0]  span;
      logic [WordWidth-1:0]  raw;
   } xrg_entry_type;

   // queue status seen by the back end
   typedef struct packed {
      logic empty;
      logic full;
   } xrg_qstat_type;

endpackage

`default_nettype wire

FILE: rtl/xrg_front.sv
// Front end: seed registers, generator state, request classification.
`timescale 1ns / 1ps
`default_nettype none

module xrg_front import xrg_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr,
   input  wire logic [SeedIdxWidth-1:0] csr_idx,
   input  wire logic [WordWidth-1:0]    csr_wdata,
   output logic      [WordWidth-1:0]    csr_rdata,
   input  wire logic                    req_accept,
   input  wire logic [BoundWidth-1:0]   lower_bound,
   input  wire logic [BoundWidth-1:0]   upper_bound,
   output xrg_entry_type                entry
);

   logic [WordWidth-1:0] seed_ff  [SeedCount];
   logic [WordWidth-1:0] state_ff [SeedCount];
   logic [WordWidth-1:0] state_in [SeedCount];
   logic [WordWidth-1:0] sum03, raw, t, s0x, s1x, s2x, s3x;
   logic                 bad;

   assign bad   = (upper_bound <= lower_bound);
   assign sum03 = state_ff[0] + state_ff[3];
   assign raw   = {sum03[40:0], sum03[63:41]} + state_ff[0];

   always_comb begin
      t   = {state_ff[1][46:0], 17'd0};
      s2x = state_ff[2] ^ state_ff[0];
      s3x = state_ff[3] ^ state_ff[1];
      s1x = state_ff[1] ^ s2x;
      s0x = state_ff[0] ^ s3x;
      state_in[0] = s0x;
      state_in[1] = s1x;
      state_in[2] = s2x ^ t;
      state_in[3] = {s3x[18:0], s3x[63:19]};
   end

   always_comb begin
      entry.bad   = bad;
      entry.lower = lower_bound;
      entry.span  = {1'b0, upper_bound} - {1'b0, lower_bound} + SpanWidth'(1);
      entry.raw   = bad ? '0 : raw;
   end

   assign csr_rdata = seed_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff[RegSeed0]  <= Seed0Reset;
         seed_ff[RegSeed1]  <= Seed1Reset;
         seed_ff[RegSeed2]  <= Seed2Reset;
         seed_ff[RegSeed3]  <= Seed3Reset;
         state_ff[RegSeed0] <= Seed0Reset;
         state_ff[RegSeed1] <= Seed1Reset;
         state_ff[RegSeed2] <= Seed2Reset;
         state_ff[RegSeed3] <= Seed3Reset;
      end else if (csr_wr) begin
         seed_ff[csr_idx]  <= csr_wdata;
         state_ff[csr_idx] <= csr_wdata;
      end else if (req_accept && !bad) begin
         for (int i = 0; i < SeedCount; i++) begin
            state_ff[i] <= state_in[i];
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/xrg_queue.sv
// Short FIFO between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module xrg_queue import xrg_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire xrg_entry_type push_data,
   input  wire logic          pop,
   output xrg_entry_type      pop_data,
   output xrg_qstat_type      stat
);

   xrg_entry_type            mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wptr_ff, rptr_ff;
   logic [QueueCntWidth-1:0] count_ff;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QueueCntWidth'(QueueDepth));
   assign pop_data   = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + QueuePtrWidth'(1);
         if (pop)  rptr_ff <= rptr_ff + QueuePtrWidth'(1);
         count_ff <= count_ff + QueueCntWidth'(push) - QueueCntWidth'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !push) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> !pop) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntWidth'(QueueDepth)) else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/xrg_back.sv
// Back end: fixed-point range scaling pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

module xrg_back import xrg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire xrg_qstat_type         qstat,
   input  wire xrg_entry_type         qdata,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [BoundWidth-1:0] ranged_value,
   output logic      [WordWidth-1:0]  raw_output,
   output logic                       bad_range
);

   localparam int FracWidth = 53;
   localparam int FracHiW   = FracWidth - BoundWidth;
   localparam int P0Width   = BoundWidth + SpanWidth;
   localparam int P1Width   = FracHiW + SpanWidth;

   logic                  adv;
   logic [FracWidth-1:0]  frac;

   // stage 1: partial products
   logic                  s1_valid_ff;
   logic                  s1_bad_ff;
   logic [BoundWidth-1:0] s1_lower_ff;
   logic [WordWidth-1:0]  s1_raw_ff;
   logic [P0Width-1:0]    s1_p0_ff;
   logic [P1Width-1:0]    s1_p1_ff;

   // stage 2: combined product, already scaled by 2^-32
   logic                  s2_valid_ff;
   logic                  s2_bad_ff;
   logic [BoundWidth-1:0] s2_lower_ff;
   logic [WordWidth-1:0]  s2_raw_ff;
   logic [P1Width-1:0]    s2_mid_ff;

   // result register
   logic                  out_valid_ff;
   logic [BoundWidth-1:0] out_value_ff;
   logic [WordWidth-1:0]  out_raw_ff;
   logic                  out_bad_ff;

   assign adv  = !out_valid_ff || rsp_ready;
   assign pop  = adv && !qstat.empty;
   assign frac = qdata.raw[WordWidth-1:WordWidth-FracWidth];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bad_ff   <= qdata.bad;
         s1_lower_ff <= qdata.lower;
         s1_raw_ff   <= qdata.raw;
         s1_p0_ff    <= P0Width'(frac[BoundWidth-1:0]) * P0Width'(qdata.span);
         s1_p1_ff    <= P1Width'(frac[FracWidth-1:BoundWidth]) * P1Width'(qdata.span);

         s2_bad_ff   <= s1_bad_ff;
         s2_lower_ff <= s1_lower_ff;
         s2_raw_ff   <= s1_raw_ff;
         s2_mid_ff   <= s1_p1_ff + P1Width'(s1_p0_ff[P0Width-1:BoundWidth]);

         out_bad_ff   <= s2_bad_ff;
         out_raw_ff   <= s2_raw_ff;
         // a full 2^32 span lands here too: mid is then the fraction itself
         out_value_ff <= s2_bad_ff ? '0
                         : s2_lower_ff + s2_mid_ff[FracWidth-1:FracWidth-BoundWidth];
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign ranged_value = out_value_ff;
   assign raw_output   = out_raw_ff;
   assign bad_range    = out_bad_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_bad_ff) |-> (out_value_ff == '0 && out_raw_ff == '0))
      else $error("bad range result carries nonzero data");
   a_mid_fits: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_bad_ff) |-> !s2_mid_ff[P1Width-1])
      else $error("scaled product exceeds fraction range");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!adv && s2_valid_ff) |=> (s2_valid_ff && $stable(s2_mid_ff)))
      else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

FILE: rtl/xoshiro256pp_range_generator_top.sv
// Top level of the xoshiro256++ range generator.
//
//  channel  dir   handshake               payload
//  req      in    req_tvalid/req_tready   tdata[31:0] lower_bound, [63:32] upper_bound
//  rsp      out   rsp_tvalid/rsp_tready   tdata[31:0] ranged_value, [95:32] raw_output;
//                                         tuser[0] bad_range
//  csr      in    APB, pready tied high   seed_word0..3 at 0x00, 0x08, 0x10, 0x18
//
// One request per cycle sustained while rsp_tready is high; the state update sits in
// the front end and completes in the accept cycle. A request reaches rsp_tvalid through
// the queue write at the accept edge, two multiply/add stages and the result register.
// Reset is synchronous; seeds and state load their reset values at once.
// A stalled rsp freezes the back pipeline; the four-entry queue then fills and
// drops req_tready.
`timescale 1ns / 1ps
`default_nettype none

module xoshiro256pp_range_generator_top import xrg_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [63:0]             req_tdata,   // lower_bound, upper_bound
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [95:0]             rsp_tdata,   // ranged_value, raw_output
   output logic      [0:0]              rsp_tuser,   // bad_range
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [WordWidth-1:0]    csr_pwdata,
   output logic      [WordWidth-1:0]    csr_prdata,
   output logic                         csr_pready
);

   xrg_entry_type         push_entry, pop_entry;
   xrg_qstat_type         qstat;
   logic                  req_accept, csr_wr, pop;
   logic [BoundWidth-1:0] ranged_value;
   logic [WordWidth-1:0]  raw_output;
   logic                  bad_range;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_tready = !qstat.full;
   assign req_accept = req_tvalid && req_tready;

   xrg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr      (csr_wr),
      .csr_idx     (csr_paddr[CsrAddrWidth-1:CsrAddrWidth-SeedIdxWidth]),
      .csr_wdata   (csr_pwdata),
      .csr_rdata   (csr_prdata),
      .req_accept  (req_accept),
      .lower_bound (req_tdata[BoundWidth-1:0]),
      .upper_bound (req_tdata[2*BoundWidth-1:BoundWidth]),
      .entry       (push_entry)
   );

   xrg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .stat      (qstat)
   );

   xrg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .qstat        (qstat),
      .qdata        (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .ranged_value (ranged_value),
      .raw_output   (raw_output),
      .bad_range    (bad_range)
   );

   assign rsp_tdata = {raw_output, ranged_value};
   assign rsp_tuser = bad_range;

endmodule

`default_nettype wire

FILE: sim/tb_xoshiro256pp_range_generator_top.sv
// Self-checking testbench for the xoshiro256++ range generator top level.
`timescale 1ns / 1ps

module tb_xoshiro256pp_range_generator_top import xrg_pkg::*;;

   localparam int StallLimit = 2000;  // cycles without any transaction
   localparam int HoldCycles = 120;   // long receiver hold-off
   localparam int MaxReports = 50;

   typedef struct {
      logic [BoundWidth-1:0] value;
      logic [WordWidth-1:0]  raw;
      logic                  bad;
   } range_draw_type;

   // Tracks the generator state and the draws still owed by the block.
   class range_draw_checker;
      logic [WordWidth-1:0] gen_word[SeedCount];
      range_draw_type       pending_draws[$];
      int                   failures;
      int                   requests;
      int                   empty_ranges;
      int                   checked;
      int                   seed_sets;

      function new();
         gen_word[0] = Seed0Reset;
         gen_word[1] = Seed1Reset;
         gen_word[2] = Seed2Reset;
         gen_word[3] = Seed3Reset;
         seed_sets   = 1;
      endfunction

      function void load_seed(logic [SeedIdxWidth-1:0] idx, logic [WordWidth-1:0] seed);
         gen_word[idx] = seed;
      endfunction

      function int pending_count();
         return pending_draws.size();
      endfunction

      function logic [WordWidth-1:0] rotl(logic [WordWidth-1:0] v, int k);
         return (v << k) | (v >> (WordWidth - k));
      endfunction

      function logic [WordWidth-1:0] advance_state();
         logic [WordWidth-1:0] raw;
         logic [WordWidth-1:0] carry;
         raw   = rotl(gen_word[0] + gen_word[3], 23) + gen_word[0];
         carry = gen_word[1] << 17;
         gen_word[2] ^= gen_word[0];
         gen_word[3] ^= gen_word[1];
         gen_word[1] ^= gen_word[2];
         gen_word[0] ^= gen_word[3];
         gen_word[2] ^= carry;
         gen_word[3] = rotl(gen_word[3], 45);
         return raw;
      endfunction

      function void note_request(logic [BoundWidth-1:0] lo, logic [BoundWidth-1:0] hi);
         range_draw_type       d;
         logic [SpanWidth-1:0] span;
         logic [52:0]          frac;
         logic [85:0]          product;
         requests++;
         if (hi <= lo) begin
            // empty range: error flag, zero payload, state untouched
            d.value = '0;
            d.raw   = '0;
            d.bad   = 1'b1;
            empty_ranges++;
         end else begin
            d.raw   = advance_state();
            d.bad   = 1'b0;
            span    = {1'b0, hi} - {1'b0, lo} + 1'b1;
            frac    = d.raw[WordWidth-1:11];
            product = frac * span;
            d.value = lo + 32'(product[85:53]);
         end
         pending_draws.push_back(d);
      endfunction

      function void report(string field, logic [WordWidth-1:0] exp_v,
                           logic [WordWidth-1:0] act_v);
         failures++;
         if (failures <= MaxReports)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
      endfunction

      function void check_draw(logic [BoundWidth-1:0] value, logic [WordWidth-1:0] raw,
                               logic bad);
         range_draw_type d;
         if (pending_draws.size() == 0) begin
            failures++;
            if (failures <= MaxReports)
               $display("%0t: unexpected response, expected none, actual value %h raw %h bad %b",
                        $time, value, raw, bad);
            return;
         end
         d = pending_draws.pop_front();
         checked++;
         if (value !== d.value)
            report("ranged_value", WordWidth'(d.value), WordWidth'(value));
         if (raw !== d.raw) report("raw_output", d.raw, raw);
         if (bad !== d.bad) report("bad_range", WordWidth'(d.bad), WordWidth'(bad));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [63:0]             req_tdata = '0;   // lower_bound, upper_bound
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [95:0]             rsp_tdata;        // ranged_value, raw_output
   logic [0:0]              rsp_tuser;        // bad_range
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [WordWidth-1:0]    csr_pwdata = '0;
   logic [WordWidth-1:0]    csr_prdata;
   logic                    csr_pready;

   range_draw_checker draws = new();
   int req_idle_pct = 7;
   int rsp_idle_pct = 7;
   int rsp_hold = 0;
   int hold_asks = 0;
   int holds_taken = 0;
   int stuck_cycles = 0;

   xoshiro256pp_range_generator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off when one is asked for
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else if (hold_asks != holds_taken) begin
         rsp_tready  <= 1'b0;
         rsp_hold    <= HoldCycles;
         holds_taken <= holds_taken + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         draws.check_draw(rsp_tdata[31:0], rsp_tdata[95:32], rsp_tuser[0]);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_request(input logic [31:0] lo, input logic [31:0] hi);
      req_tvalid <= 1'b1;
      req_tdata  <= {hi, lo};
      do @(posedge clock); while (!req_tready);
      draws.note_request(lo, hi);
   endtask

   task automatic pause_requests(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(99) < req_idle_pct)
         pause_requests($urandom_range(6, 1));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (draws.pending_count() != 0) @(posedge clock);
   endtask

   task automatic write_seed(input logic [SeedIdxWidth-1:0] idx,
                             input logic [WordWidth-1:0] seed);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= seed;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      draws.load_seed(idx, seed);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_all_seeds(input logic [WordWidth-1:0] s0, input logic [WordWidth-1:0] s1,
                                  input logic [WordWidth-1:0] s2, input logic [WordWidth-1:0] s3);
      write_seed(RegSeed0, s0);
      write_seed(RegSeed1, s1);
      write_seed(RegSeed2, s2);
      write_seed(RegSeed3, s3);
      draws.seed_sets++;
   endtask

   function automatic logic [WordWidth-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
      int kind;
      int delta;
      int k;
      kind = $urandom_range(99);
      if (kind < 12) begin
         lo = $urandom;
         hi = $urandom_range(lo, 0);
      end else if (kind < 40) begin
         delta = $urandom_range(255, 1);
         hi    = $urandom_range(32'hFFFF_FFFF, delta);
         lo    = hi - delta;
      end else if (kind < 75) begin
         lo = $urandom;
         hi = $urandom;
         if (hi < lo) {lo, hi} = {hi, lo};
      end else if (kind < 88) begin
         // power-of-two spans up to the full 32-bit range
         k  = $urandom_range(32, 1);
         lo = '0;
         hi = 32'((64'd1 << k) - 1);
      end else begin
         lo = $urandom_range(3);
         hi = 32'hFFFF_FFFF - $urandom_range(3);
      end
   endtask

   task automatic run_random(input int count, input int hold_at, input int pause_at);
      logic [31:0] lo;
      logic [31:0] hi;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_asks++;
         if (i == pause_at) drain();
         pick_bounds(lo, hi);
         send_request(lo, hi);
         maybe_idle();
      end
   endtask

   initial begin
      logic [31:0] dir_lo[14];
      logic [31:0] dir_hi[14];
      dir_lo = '{32'h0, 32'h0, 32'hFFFF_FFFE, 32'h5, 32'hFFFF_FFFF, 32'h0,
                 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h1, 32'h0, 32'h8000_0000};
      dir_hi = '{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h5, 32'h0, 32'h0,
                 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFF};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset seeds: bound extremes, empty ranges, full-width span
      foreach (dir_lo[i]) begin
         send_request(dir_lo[i], dir_hi[i]);
         maybe_idle();
      end
      drain();

      // all-zero seed: generator stuck at zero
      write_all_seeds('0, '0, '0, '0);
      run_random(20, -1, -1);
      drain();

      write_all_seeds('1, '1, '1, '1);
      run_random(300, -1, -1);
      drain();

      // receiver hold-off fills the block, then a full drain mid-stream
      write_all_seeds(random_word(), random_word(), random_word(), random_word());
      run_random(400, 100, 250);
      drain();

      // back-to-back stretch with no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_all_seeds(random_word(), random_word(), random_word(), random_word());
      run_random(600, -1, -1);
      drain();

      // reload a single state word only
      req_idle_pct = 7;
      rsp_idle_pct = 7;
      write_seed(RegSeed2, random_word());
      run_random(700, 350, -1);
      drain();

      repeat (12) @(posedge clock);
      $display("Covered %0d requests (%0d with an empty range) under %0d seed settings;",
               draws.requests, draws.empty_ranges, draws.seed_sets);
      $display("%0d responses checked, including a partial reseed and a long output stall.",
               draws.checked);
      if (draws.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
